>>> sv/rpn_pkg.sv
// shared constants, opcode and status codes, and controller/datapath struct types
// for the rpn stack calculator; no dependencies
package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int OPCODE_W    = 4;
  localparam int STATUS_W    = 2;
  localparam int DIV_STEP_W  = $clog2(DATA_W);

  localparam logic [OPCODE_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_SUB   = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL   = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_TOP   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_ALL   = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_ABS   = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_NEG   = 4'd9;
  localparam logic [OPCODE_W-1:0] OP_DUP   = 4'd10;

  localparam logic [STATUS_W-1:0] ST_VALUE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic                latch;
    logic                push_wr;
    logic                clear;
    logic                alu_load;
    logic                div_start;
    logic                div_load;
    logic                wb;
    logic                walk_init;
    logic                walk_step;
    logic                walking;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_last;
  } rpn_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                cnt_zero;
    logic                cnt_lt2;
    logic                cnt_full;
    logic                b_zero;
    logic                div_done;
    logic                out_free;
    logic                walk_last;
  } rpn_sts_t;

endpackage

>>> sv/rpn_cmd_if.sv
// input channel of the rpn stack calculator: valid/ready plus one operation item
// depends on rpn_pkg
interface rpn_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [rpn_pkg::OPCODE_W-1:0]        opcode;
  logic signed [rpn_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

>>> sv/rpn_res_if.sv
// result channel of the rpn stack calculator: valid/ready plus one result item
// depends on rpn_pkg
interface rpn_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpn_pkg::DATA_W-1:0]   data;
  logic [rpn_pkg::STATUS_W-1:0]        status;
  logic                                last;

  modport source (output valid, output data, output status, output last, input ready);
  modport sink   (input valid, input data, input status, input last, output ready);
endinterface

>>> sv/rpn_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on rpn_pkg
module rpn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rpn_pkg::DATA_W-1:0] dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [rpn_pkg::DATA_W-1:0] quotient
);
  import rpn_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [DATA_W:0]       rem;
  logic [DATA_W-1:0]     quo;
  logic [DATA_W-1:0]     dvs;
  logic                  neg;

  logic [DATA_W:0]       shifted;
  logic [DATA_W+1:0]     diff;
  logic [DATA_W:0]       rem_next;
  logic [DATA_W-1:0]     quo_next;

  always_comb begin
    shifted = {rem[DATA_W-1:0], quo[DATA_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    if (!diff[DATA_W+1]) begin
      rem_next = diff[DATA_W:0];
      quo_next = {quo[DATA_W-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      quo_next = {quo[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + DIV_STEP_W'(1);
        if (step == DIV_STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand magnitudes, most negative value maps to its unsigned magnitude
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dvs <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

endmodule

>>> sv/rpn_dp.sv
// datapath: stack memory, entry count, alu, divider, print-all walk pointer,
// result register; depends on rpn_pkg and rpn_div
module rpn_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  rpn_pkg::rpn_ctl_t           ctl,
  output rpn_pkg::rpn_sts_t           sts,
  input  logic [rpn_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [rpn_pkg::DATA_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rpn_pkg::DATA_W-1:0]  out_data,
  output logic [rpn_pkg::STATUS_W-1:0] out_status,
  output logic                        out_last
);
  import rpn_pkg::*;

  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rd_a;
  logic [DATA_W-1:0]   rd_b;
  logic [ADDR_W-1:0]   ra;
  logic [ADDR_W-1:0]   rb;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [OPCODE_W-1:0] op;
  logic [DATA_W-1:0]   val;
  logic [DATA_W-1:0]   res;
  logic [DATA_W-1:0]   alu_res;
  logic [ADDR_W-1:0]   walk_idx;
  logic [ADDR_W-1:0]   walk_idx_next;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic                div_done;
  logic [DATA_W-1:0]   quotient;

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (rd_a),
    .divisor  (rd_b),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    if (ctl.walk_init) begin
      walk_idx_next = ADDR_W'(count - CNT_W'(1));
    end else if (ctl.walk_step) begin
      walk_idx_next = walk_idx - ADDR_W'(1);
    end else begin
      walk_idx_next = walk_idx;
    end
  end

  // port a: second from top, port b: top or the walk pointer prefetch
  assign ra = ADDR_W'(count - CNT_W'(2));
  assign rb = ctl.walking ? walk_idx_next : ADDR_W'(count - CNT_W'(1));

  always_comb begin
    case (op)
      OP_ADD:  alu_res = rd_a + rd_b;
      OP_SUB:  alu_res = rd_a - rd_b;
      OP_MUL:  alu_res = DATA_W'(rd_a * rd_b);
      OP_ABS:  alu_res = rd_b[DATA_W-1] ? (DATA_W'(0) - rd_b) : rd_b;
      OP_NEG:  alu_res = DATA_W'(0) - rd_b;
      default: alu_res = rd_b;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = ADDR_W'(count);
    mem_wdata  = res;
    count_next = count;
    if (ctl.push_wr) begin
      mem_we     = 1'b1;
      mem_wdata  = val;
      count_next = count + CNT_W'(1);
    end else if (ctl.wb) begin
      unique case (op) inside
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          mem_we     = 1'b1;
          mem_waddr  = ADDR_W'(count - CNT_W'(2));
          count_next = count - CNT_W'(1);
        end
        OP_ABS, OP_NEG: begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(count - CNT_W'(1));
        end
        OP_DUP: begin
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end else if (ctl.clear) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op  <= in_opcode;
      val <= in_value;
    end
    if (ctl.alu_load) begin
      res <= alu_res;
    end else if (ctl.div_load) begin
      res <= quotient;
    end
    walk_idx <= walk_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data   <= (ctl.emit_status == ST_VALUE) ? rd_b : '0;
      out_status <= ctl.emit_status;
      out_last   <= ctl.emit_last;
    end
  end

  assign sts.op        = op;
  assign sts.cnt_zero  = (count == '0);
  assign sts.cnt_lt2   = (count < CNT_W'(2));
  assign sts.cnt_full  = (count == CNT_W'(STACK_DEPTH));
  assign sts.b_zero    = (rd_b == '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.walk_last = (walk_idx == '0);

endmodule

>>> sv/rpn_ctrl.sv
// controller state machine: decodes each operation, checks stack bounds and
// sequences the datapath; depends on rpn_pkg
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  output rpn_pkg::rpn_ctl_t ctl,
  input  rpn_pkg::rpn_sts_t sts
);
  import rpn_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_WB     = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_WALK   = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    code_next  = code;
    ctl.walking = (state == S_WALK);
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (sts.op) inside
          OP_PUSH: begin
            if (sts.cnt_full) begin
              code_next  = ST_FULL;
              state_next = S_EMIT;
            end else begin
              ctl.push_wr = 1'b1;
            end
          end
          OP_DUP: begin
            if (sts.cnt_zero) begin
              code_next  = ST_EMPTY;
              state_next = S_EMIT;
            end else if (sts.cnt_full) begin
              code_next  = ST_FULL;
              state_next = S_EMIT;
            end else begin
              state_next = S_FETCH;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (sts.cnt_lt2) begin
              code_next  = ST_EMPTY;
              state_next = S_EMIT;
            end else begin
              state_next = S_FETCH;
            end
          end
          OP_TOP, OP_ABS, OP_NEG: begin
            if (sts.cnt_zero) begin
              code_next  = ST_EMPTY;
              state_next = S_EMIT;
            end else begin
              state_next = S_FETCH;
            end
          end
          OP_ALL: begin
            if (!sts.cnt_zero) begin
              ctl.walk_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          OP_CLEAR: begin
            ctl.clear = 1'b1;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_FETCH: begin
        unique case (sts.op)
          OP_DIV: begin
            if (sts.b_zero) begin
              code_next  = ST_DIVZERO;
              state_next = S_EMIT;
            end else begin
              ctl.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          OP_TOP: begin
            code_next  = ST_VALUE;
            state_next = S_EMIT;
          end
          default: begin
            ctl.alu_load = 1'b1;
            state_next   = S_WB;
          end
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          ctl.div_load = 1'b1;
          state_next   = S_WB;
        end
      end
      S_WB: begin
        ctl.wb     = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = code;
          ctl.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts.out_free) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_VALUE;
          ctl.emit_last   = sts.walk_last;
          ctl.walk_step   = 1'b1;
          if (sts.walk_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_VALUE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

>>> sv/rpn_stack_calculator_core.sv
// top level of the rpn stack calculator: controller, datapath and channel wiring
// depends on rpn_pkg, rpn_cmd_if, rpn_res_if, rpn_ctrl, rpn_dp
//
// One operation item at a time is taken on cmd and acted on against a stack of
// STACK_DEPTH 32-bit entries held in a single memory with registered reads.
// cmd.ready is high only while the block is idle. Push, clear and unused
// opcodes go from decode back to idle; add, sub, mul, abs, neg and dup pass
// through fetch and write-back; div also waits on the divider, which retires
// one quotient bit per cycle; top and divide by zero go from fetch, the other
// errors from decode, to emit and wait there on res; print-all makes one
// memory read per entry, also waiting on res. A result sits in an output
// register, so the next item is accepted while it waits. Errors come out as a
// single item with data zero and last set; print-all on an empty stack gives
// no result. No clearing pass is needed after reset.
module rpn_stack_calculator_core (
  input  logic      clk,
  input  logic      rst,
  rpn_cmd_if.sink   cmd,
  rpn_res_if.source res
);
  import rpn_pkg::*;

  rpn_ctl_t            ctl;
  rpn_sts_t            sts;
  logic [DATA_W-1:0]   out_data;

  // controller: decode, bound checks, sequencing
  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // datapath: stack memory, count, alu, divider, result register
  rpn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_opcode  (cmd.opcode),
    .in_value   (DATA_W'(cmd.push_value)),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_data   (out_data),
    .out_status (res.status),
    .out_last   (res.last)
  );

  // stored as raw bits, shown signed on the port
  assign res.data = $signed(out_data);

endmodule

>>> sv/rpn_checker.sv
// port-level checks on the rpn stack calculator, attached by bind
// depends on rpn_pkg and rpn_stack_calculator_core
module rpn_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [rpn_pkg::DATA_W-1:0]   res_data,
  input logic [rpn_pkg::STATUS_W-1:0] res_status,
  input logic                         res_last
);
  import rpn_pkg::*;

  // held result stays put while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data) && $stable(res_status)
      && $stable(res_last))
    else $error("result changed while stalled");

  // an error item carries zero data and ends its item
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != ST_VALUE) |-> (res_data == '0) && res_last)
    else $error("error result not zero or not last");

  // one item in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("accepted a second item without finishing the first");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> cmd_ready && !res_valid)
    else $error("block not idle after reset");

endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_data   (res.data),
  .res_status (res.status),
  .res_last   (res.last)
);
